/* rtl/four_level_page_table_walker_unit_macros.svh */
// four_level_page_table_walker_unit_macros.svh: assertion macros for the walker
// no dependencies; taken in by the modules that carry assertions
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PTW_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page table walker check failed");

// consequent must hold in the cycle after the antecedent
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page table walker check failed");

`endif

/* rtl/ptw_pkg.sv */
// ptw_pkg.sv: widths, entry bit positions, codes and control structs
// shared by the page table walker controller, datapath and top level
package ptw_pkg;

  // default table memory depth in 64-bit words
  localparam int MEM_WORDS_DEF = 4096;

  // field widths
  localparam int ROOT_W  = 40;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENT_W   = 64;
  localparam int WIDX_W  = 12;
  localparam int IDX_W   = 9;
  localparam int TADDR_W = ROOT_W + IDX_W;
  localparam int PSZ_W   = 2;

  // entry bit positions
  localparam int BIT_P  = 0;
  localparam int BIT_RW = 1;
  localparam int BIT_US = 2;
  localparam int BIT_PS = 7;
  localparam int BIT_G  = 8;
  localparam int BIT_NX = 63;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // level of the entry held in the read register
  localparam logic [1:0] LVL_1 = 2'd0;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_4 = 2'd3;

  // page size codes
  localparam logic [PSZ_W-1:0] PSZ_4K = 2'd0;
  localparam logic [PSZ_W-1:0] PSZ_2M = 2'd1;
  localparam logic [PSZ_W-1:0] PSZ_1G = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic tbl_wr;
    logic start;
    logic issue;
    logic fin_leaf;
    logic fin_miss;
  } ptw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic root_oob;
    logic wr_oob;
    logic present;
    logic leaf;
    logic next_oob;
  } ptw_stat_t;

endpackage

/* rtl/ptw_dp.sv */
// ptw_dp.sv: walker datapath with table memory, root register, walk registers
// and result word registers; uses ptw_pkg, driven by ptw_ctrl commands
module ptw_dp #(
  parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ptw_pkg::ptw_cmd_t           ctl_cmd,
  output ptw_pkg::ptw_stat_t          stat,
  input  logic                        cfg_wr_en,
  input  logic [ptw_pkg::ROOT_W-1:0]  cfg_wr_data,
  input  logic [ptw_pkg::WIDX_W-1:0]  word_index,
  input  logic [ptw_pkg::ENT_W-1:0]   write_data,
  input  logic [ptw_pkg::VA_W-1:0]    virt_addr,
  output logic                        mapped,
  output logic [ptw_pkg::PA_W-1:0]    phys_addr,
  output logic [ptw_pkg::PSZ_W-1:0]   size_code,
  output logic                        writable,
  output logic                        executable,
  output logic                        user_access,
  output logic                        global_page
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [ptw_pkg::TADDR_W-1:0] LIMIT = ptw_pkg::TADDR_W'(MEM_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

  logic [ptw_pkg::ENT_W-1:0]   mem [MEM_WORDS];
  logic [ptw_pkg::ENT_W-1:0]   rd;
  logic [ptw_pkg::ROOT_W-1:0]  root;
  logic [ptw_pkg::VA_W-1:0]    va;
  logic [1:0]                  level;
  logic [AW-1:0]               clr_addr;

  logic [ptw_pkg::IDX_W-1:0]   idx_next;
  logic [ptw_pkg::TADDR_W-1:0] root_taddr;
  logic [ptw_pkg::TADDR_W-1:0] walk_taddr;
  logic [ptw_pkg::TADDR_W-1:0] rd_taddr;
  logic [ptw_pkg::TADDR_W-1:0] wr_taddr;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ptw_pkg::ENT_W-1:0]   mem_wdata;
  logic [ptw_pkg::PA_W-1:0]    leaf_pa;
  logic [ptw_pkg::PSZ_W-1:0]   leaf_size;

  // table word addresses: frame number above the nine index bits
  always_comb begin
    case (level)
      ptw_pkg::LVL_4: idx_next = va[38:30];
      ptw_pkg::LVL_3: idx_next = va[29:21];
      ptw_pkg::LVL_2: idx_next = va[20:12];
      default:        idx_next = va[20:12];
    endcase
  end

  assign root_taddr = {root, virt_addr[47:39]};
  assign walk_taddr = {rd[51:12], idx_next};
  assign rd_taddr   = ctl_cmd.start ? root_taddr : walk_taddr;
  assign wr_taddr   = ptw_pkg::TADDR_W'(word_index);

  // status back to the controller
  always_comb begin
    stat.clr_last = (clr_addr == LAST_WORD);
    stat.root_oob = (root_taddr >= LIMIT);
    stat.wr_oob   = (wr_taddr >= LIMIT);
    stat.present  = rd[ptw_pkg::BIT_P];
    stat.leaf     = (level == ptw_pkg::LVL_1) ||
                    (rd[ptw_pkg::BIT_PS] &&
                     ((level == ptw_pkg::LVL_3) || (level == ptw_pkg::LVL_2)));
    stat.next_oob = (walk_taddr >= LIMIT);
  end

  // write port shared by the clearing pass and table writes
  assign mem_we    = ctl_cmd.clr_step || ctl_cmd.tbl_wr;
  assign mem_waddr = ctl_cmd.clr_step ? clr_addr : wr_taddr[AW-1:0];
  assign mem_wdata = ctl_cmd.clr_step ? '0 : write_data;

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl_cmd.issue) begin
      rd <= mem[rd_taddr[AW-1:0]];
    end
  end

  // root table frame
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_wr_en) begin
      root <= cfg_wr_data;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl_cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // walk level and latched virtual address
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= ptw_pkg::LVL_4;
    end else if (ctl_cmd.start) begin
      level <= ptw_pkg::LVL_4;
    end else if (ctl_cmd.issue) begin
      level <= level - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.start) begin
      va <= virt_addr;
    end
  end

  // leaf frame and offset by page size
  always_comb begin
    case (level)
      ptw_pkg::LVL_3: begin
        leaf_pa   = {rd[51:30], va[29:0]};
        leaf_size = ptw_pkg::PSZ_1G;
      end
      ptw_pkg::LVL_2: begin
        leaf_pa   = {rd[51:21], va[20:0]};
        leaf_size = ptw_pkg::PSZ_2M;
      end
      default: begin
        leaf_pa   = {rd[51:12], va[11:0]};
        leaf_size = ptw_pkg::PSZ_4K;
      end
    endcase
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (ctl_cmd.fin_leaf) begin
      mapped      <= 1'b1;
      phys_addr   <= leaf_pa;
      size_code   <= leaf_size;
      writable    <= rd[ptw_pkg::BIT_RW];
      executable  <= !rd[ptw_pkg::BIT_NX];
      user_access <= rd[ptw_pkg::BIT_US];
      global_page <= rd[ptw_pkg::BIT_G];
    end else if (ctl_cmd.fin_miss) begin
      mapped      <= 1'b0;
      phys_addr   <= '0;
      size_code   <= ptw_pkg::PSZ_4K;
      writable    <= 1'b0;
      executable  <= 1'b0;
      user_access <= 1'b0;
      global_page <= 1'b0;
    end
  end

endmodule

/* rtl/ptw_ctrl.sv */
// ptw_ctrl.sv: walker controller state machine, input and output handshakes
// uses ptw_pkg and the assertion macros header; steers ptw_dp
`include "four_level_page_table_walker_unit_macros.svh"

module ptw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               cmd,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ptw_pkg::ptw_stat_t stat,
  output ptw_pkg::ptw_cmd_t  ctl_cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_MISS  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;
  logic       fin_any;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_any  = ctl_cmd.fin_leaf || ctl_cmd.fin_miss;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl_cmd    = '0;
    case (state)
      S_CLEAR: begin
        ctl_cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd == ptw_pkg::CMD_WRITE) begin
            ctl_cmd.tbl_wr = !stat.wr_oob;
          end else begin
            ctl_cmd.start = 1'b1;
            if (stat.root_oob) begin
              state_next = S_MISS;
            end else begin
              ctl_cmd.issue = 1'b1;
              state_next    = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        // absent entry or next table outside memory ends unmapped
        if (!stat.present || (!stat.leaf && stat.next_oob)) begin
          if (out_free) begin
            ctl_cmd.fin_miss = 1'b1;
            state_next       = S_IDLE;
          end
        end else if (stat.leaf) begin
          if (out_free) begin
            ctl_cmd.fin_leaf = 1'b1;
            state_next       = S_IDLE;
          end
        end else begin
          ctl_cmd.issue = 1'b1;
        end
      end
      S_MISS: begin
        if (out_free) begin
          ctl_cmd.fin_miss = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // output word slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_any) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `PTW_ASSERT_SAME(a_fin_slot_free, clk, rst, fin_any, out_free)
  `PTW_ASSERT_NEXT(a_fin_shows_word, clk, rst, fin_any, out_valid)
  `PTW_ASSERT_SAME(a_issue_no_fin, clk, rst, ctl_cmd.issue, !fin_any)
  `PTW_ASSERT_SAME(a_clear_alone, clk, rst, ctl_cmd.clr_step, !ctl_cmd.tbl_wr && !ctl_cmd.start)

endmodule

/* rtl/four_level_page_table_walker_unit.sv */
// Four-level page table walker: a write word leaves the input free for the next word;
// a translate word stalls input until its walk ends: up to four dependent table reads
// through the one registered read port, then a load of the result word registers.
// The result word and out_valid are registered together; a walk that ends while the
// previous result word is still stalled waits until that word is taken.
// After reset (synchronous, active high) the table memory is cleared one word a cycle,
// all MEM_WORDS words, and input is stalled throughout.
module four_level_page_table_walker_unit #(
  parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ptw_pkg::ROOT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [ptw_pkg::WIDX_W-1:0]  word_index,
  input  logic [ptw_pkg::ENT_W-1:0]   write_data,
  input  logic [ptw_pkg::VA_W-1:0]    virt_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        mapped,
  output logic [ptw_pkg::PA_W-1:0]    phys_addr,
  output logic [ptw_pkg::PSZ_W-1:0]   size_code,
  output logic                        writable,
  output logic                        executable,
  output logic                        user_access,
  output logic                        global_page
);

  ptw_pkg::ptw_cmd_t  ctl_cmd;
  ptw_pkg::ptw_stat_t stat;

  // controller
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl_cmd   (ctl_cmd)
  );

  // datapath and table memory
  ptw_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl_cmd     (ctl_cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .word_index  (word_index),
    .write_data  (write_data),
    .virt_addr   (virt_addr),
    .mapped      (mapped),
    .phys_addr   (phys_addr),
    .size_code   (size_code),
    .writable    (writable),
    .executable  (executable),
    .user_access (user_access),
    .global_page (global_page)
  );

endmodule

/* sim/four_level_page_table_walker_unit_tb.sv */
`timescale 1ns / 100ps
// testbench for four_level_page_table_walker_unit: builds page tables in the walker memory,
// translates addresses through them and checks every result word against its own walk
// depends on ptw_pkg and the walker top level only

// one translation result word, field for field
typedef struct packed {
  logic                      mapped;
  logic [ptw_pkg::PA_W-1:0]  phys_addr;
  logic [ptw_pkg::PSZ_W-1:0] size_code;
  logic                      writable;
  logic                      executable;
  logic                      user_access;
  logic                      global_page;
} xlate_result_t;

class walk_scoreboard;
  logic [ptw_pkg::ENT_W-1:0]  table_words [ptw_pkg::MEM_WORDS_DEF];
  logic [ptw_pkg::ROOT_W-1:0] root_page;
  xlate_result_t              pending_xlates [$];
  int unsigned                failures;

  function new();
    foreach (table_words[i]) table_words[i] = '0;
    root_page = '0;
    failures  = 0;
  endfunction

  function void set_root(logic [ptw_pkg::ROOT_W-1:0] page);
    root_page = page;
  endfunction

  function int unsigned outstanding();
    return pending_xlates.size();
  endfunction

  // four-level walk over the local copy of the table memory
  function xlate_result_t predict_walk(logic [ptw_pkg::VA_W-1:0] va);
    xlate_result_t             r;
    logic [63:0]               base;
    logic [63:0]               word_no;
    logic [ptw_pkg::ENT_W-1:0] ent;
    int                        lvl;
    r = '0;
    base = {12'd0, root_page, 12'd0};
    for (lvl = int'(ptw_pkg::LVL_4); lvl >= int'(ptw_pkg::LVL_1); lvl--) begin
      word_no = (base >> 3) + 64'(va[12 + 9 * lvl +: 9]);
      if (word_no >= ptw_pkg::MEM_WORDS_DEF) return r;
      ent = table_words[word_no[ptw_pkg::WIDX_W-1:0]];
      if (!ent[ptw_pkg::BIT_P]) return r;
      // size bit is ignored at the top level; the bottom level is always a leaf
      if (lvl == int'(ptw_pkg::LVL_1) ||
          (lvl != int'(ptw_pkg::LVL_4) && ent[ptw_pkg::BIT_PS])) begin
        r.mapped      = 1'b1;
        r.writable    = ent[ptw_pkg::BIT_RW];
        r.executable  = !ent[ptw_pkg::BIT_NX];
        r.user_access = ent[ptw_pkg::BIT_US];
        r.global_page = ent[ptw_pkg::BIT_G];
        if (lvl == int'(ptw_pkg::LVL_3)) begin
          r.size_code = ptw_pkg::PSZ_1G;
          r.phys_addr = {ent[ptw_pkg::PA_W-1:30], va[29:0]};
        end else if (lvl == int'(ptw_pkg::LVL_2)) begin
          r.size_code = ptw_pkg::PSZ_2M;
          r.phys_addr = {ent[ptw_pkg::PA_W-1:21], va[20:0]};
        end else begin
          r.size_code = ptw_pkg::PSZ_4K;
          r.phys_addr = {ent[ptw_pkg::PA_W-1:12], va[11:0]};
        end
        return r;
      end
      base = {12'd0, ent[ptw_pkg::PA_W-1:12], 12'd0};
    end
    return r;
  endfunction

  // accepted input word: a table write or a translation to expect
  function void note_word(logic c, logic [ptw_pkg::WIDX_W-1:0] wi,
                          logic [ptw_pkg::ENT_W-1:0] wd, logic [ptw_pkg::VA_W-1:0] va);
    if (c == ptw_pkg::CMD_WRITE) begin
      if (int'(wi) < ptw_pkg::MEM_WORDS_DEF) table_words[wi] = wd;
    end else begin
      pending_xlates.push_back(predict_walk(va));
    end
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function void check_result(xlate_result_t got);
    xlate_result_t want;
    if (pending_xlates.size() == 0) begin
      $error("result word with no translation pending");
      failures++;
      return;
    end
    want = pending_xlates.pop_front();
    compare_field("mapped", 64'(want.mapped), 64'(got.mapped));
    compare_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
    compare_field("size_code", 64'(want.size_code), 64'(got.size_code));
    compare_field("writable", 64'(want.writable), 64'(got.writable));
    compare_field("executable", 64'(want.executable), 64'(got.executable));
    compare_field("user_access", 64'(want.user_access), 64'(got.user_access));
    compare_field("global_page", 64'(want.global_page), 64'(got.global_page));
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 150;
  localparam logic [ptw_pkg::ROOT_W-1:0] ROOT_TOP = '1;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [ptw_pkg::ROOT_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       cmd;
  logic [ptw_pkg::WIDX_W-1:0] word_index;
  logic [ptw_pkg::ENT_W-1:0]  write_data;
  logic [ptw_pkg::VA_W-1:0]   virt_addr;
  logic                       out_valid;
  logic                       out_stall;
  logic                       mapped;
  logic [ptw_pkg::PA_W-1:0]   phys_addr;
  logic [ptw_pkg::PSZ_W-1:0]  size_code;
  logic                       writable;
  logic                       executable;
  logic                       user_access;
  logic                       global_page;

  walk_scoreboard walks = new();
  logic idle_on = 1'b1;
  int   items_sent = 0;
  int   results_seen = 0;
  int   cycle_count = 0;

  four_level_page_table_walker_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .word_index  (word_index),
    .write_data  (write_data),
    .virt_addr   (virt_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mapped      (mapped),
    .phys_addr   (phys_addr),
    .size_code   (size_code),
    .writable    (writable),
    .executable  (executable),
    .user_access (user_access),
    .global_page (global_page)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[four_level_page_table_walker_unit] ERROR");
      $finish;
    end
  end

  // result word monitor
  always @(posedge clk) begin : result_monitor
    xlate_result_t got;
    if (rst === 1'b0 && out_valid && !out_stall) begin
      got.mapped      = mapped;
      got.phys_addr   = phys_addr;
      got.size_code   = size_code;
      got.writable    = writable;
      got.executable  = executable;
      got.user_access = user_access;
      got.global_page = global_page;
      walks.check_result(got);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one input word and wait for it to be taken
  task automatic send_word(input logic c, input logic [ptw_pkg::WIDX_W-1:0] wi,
                           input logic [ptw_pkg::ENT_W-1:0] wd,
                           input logic [ptw_pkg::VA_W-1:0] va);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    word_index <= wi;
    write_data <= wd;
    virt_addr  <= va;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walks.note_word(c, wi, wd, va);
    items_sent++;
  endtask

  task automatic put_entry(input logic [ptw_pkg::WIDX_W-1:0] wi,
                           input logic [ptw_pkg::ENT_W-1:0] wd);
    send_word(ptw_pkg::CMD_WRITE, wi, wd, ptw_pkg::VA_W'(rand64()));
  endtask

  task automatic translate(input logic [ptw_pkg::VA_W-1:0] va);
    send_word(ptw_pkg::CMD_XLATE, ptw_pkg::WIDX_W'($urandom), rand64(), va);
  endtask

  // wait for all translations, then let the walker go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (walks.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [ptw_pkg::ROOT_W-1:0] page);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= page;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    walks.set_root(page);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) put_entry(ptw_pkg::WIDX_W'($urandom), rand64());
    else translate(ptw_pkg::VA_W'(rand64()));
  endtask

  // build one walk path from a root inside the memory, sometimes broken, then probe it
  task automatic map_and_probe(input logic [ptw_pkg::ROOT_W-1:0] root);
    logic [ptw_pkg::VA_W-1:0]  va;
    logic [ptw_pkg::VA_W-1:0]  probe;
    logic [ptw_pkg::ENT_W-1:0] ent;
    logic [2:0]                tbl;
    logic [2:0]                nxt;
    int                        leaf_lvl;
    int                        flaw_lvl;
    int                        lvl;
    va       = ptw_pkg::VA_W'(rand64());
    leaf_lvl = $urandom_range(int'(ptw_pkg::LVL_1), int'(ptw_pkg::LVL_3));
    flaw_lvl = ($urandom_range(0, 4) == 0) ?
               $urandom_range(leaf_lvl, int'(ptw_pkg::LVL_4)) : -1;
    tbl      = root[2:0];
    for (lvl = int'(ptw_pkg::LVL_4); lvl >= leaf_lvl; lvl--) begin
      ent = rand64();
      ent[ptw_pkg::BIT_P] = 1'b1;
      if (lvl > leaf_lvl) begin
        // pointer; top-level size bit stays random
        nxt = 3'($urandom_range(0, 7));
        ent[ptw_pkg::PA_W-1:12] = {37'd0, nxt};
        if (lvl != int'(ptw_pkg::LVL_4)) ent[ptw_pkg::BIT_PS] = 1'b0;
        if (lvl == flaw_lvl) begin
          if ($urandom_range(0, 1) == 0) ent[ptw_pkg::BIT_P] = 1'b0;
          else ent[ptw_pkg::PA_W-1:12] = 40'($urandom) | 40'h8;
        end
      end else begin
        // leaf; bottom-level size bit stays random
        if (lvl != int'(ptw_pkg::LVL_1)) ent[ptw_pkg::BIT_PS] = 1'b1;
        if (lvl == flaw_lvl) ent[ptw_pkg::BIT_P] = 1'b0;
      end
      put_entry({tbl, va[12 + 9 * lvl +: 9]}, ent);
      tbl = nxt;
    end
    repeat ($urandom_range(1, 3)) begin
      probe = va;
      if (leaf_lvl == int'(ptw_pkg::LVL_3)) probe[29:0] = 30'($urandom);
      else if (leaf_lvl == int'(ptw_pkg::LVL_2)) probe[20:0] = 21'($urandom);
      else probe[11:0] = 12'($urandom);
      translate(probe);
    end
  endtask

  task automatic run_phase(input logic [ptw_pkg::ROOT_W-1:0] root, input int count,
                           input logic idling, input logic paths);
    int stop_at;
    settle();
    write_root(root);
    idle_on = idling;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (paths && $urandom_range(0, 3) != 0) map_and_probe(root);
      else send_noise();
    end
  endtask

  // directed walks with root page 0
  task automatic directed_walks();
    translate(48'd0);
    put_entry(12'd0, 64'h8000_0000_0000_7087);
    put_entry(12'd4095, 64'hffff_ffff_ffff_ffff);
    translate({9'd0, 9'd511, 30'h3fff_ffff});
    put_entry(12'd3584, 64'h0000_0000_0000_1001);
    put_entry(12'd512, 64'h000a_bcde_f01f_f181);
    translate({9'd0, 9'd0, 9'd0, 21'h1f_ffff});
    put_entry(12'd513, 64'h0000_0000_0000_2001);
    put_entry(12'd1024, 64'h7fff_ffff_ffff_ff87);
    translate({9'd0, 9'd0, 9'd1, 9'd0, 12'hfff});
    put_entry(12'd1025, 64'h8000_0000_0000_5001);
    translate({9'd0, 9'd0, 9'd1, 9'd1, 12'h000});
    // leaf not present
    put_entry(12'd1026, 64'hffff_ffff_ffff_fffe);
    translate({9'd0, 9'd0, 9'd1, 9'd2, 12'h5a5});
    // next table outside the memory
    put_entry(12'd1, 64'h000f_ffff_ffff_f001);
    translate({9'd1, 39'd0});
    // empty lower table
    put_entry(12'd511, 64'h0000_0000_0000_2003);
    translate(48'hffff_ffff_ffff);
    // middle level not present
    put_entry(12'd514, 64'h0000_0000_0000_2000);
    translate({9'd0, 9'd0, 9'd2, 21'd0});
  endtask

  initial begin : stimulus
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    cmd         <= ptw_pkg::CMD_WRITE;
    word_index  <= '0;
    write_data  <= '0;
    virt_addr   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_walks();
    run_phase(40'd3, 350, 1'b1, 1'b1);
    run_phase(40'd7, 350, 1'b1, 1'b1);
    run_phase(ROOT_TOP, 100, 1'b1, 1'b0);
    run_phase(40'd0, 300, 1'b1, 1'b1);
    // last stretch runs flat out
    run_phase(40'($urandom_range(0, 7)), 300, 1'b0, 1'b1);

    settle();
    if (walks.failures == 0) $display("[four_level_page_table_walker_unit] OK");
    else $display("[four_level_page_table_walker_unit] ERROR");
    $finish;
  end
endmodule
